>>> hdl/stq_pkg.sv
// ----------------------------------------------------------------------------
// stq_pkg
// Shared types and constants of the sorted timer event queue.
// ----------------------------------------------------------------------------
package stq_pkg;

  // Defaults of the top-level parameters
  localparam int unsigned DEPTH_DEF      = 32;
  localparam int unsigned TIME_WIDTH_DEF = 32;
  localparam int unsigned ID_WIDTH_DEF   = 16;

  // Most expired items sent for one tick
  localparam int unsigned MAX_RESULTS = 32;

  // Fixed payload widths on the channels
  localparam int unsigned REQ_W        = 2;
  localparam int unsigned FIELD_TIME_W = 32;
  localparam int unsigned FIELD_ID_W   = 16;
  localparam int unsigned JOB_W        = 16;
  localparam int unsigned KIND_W       = 3;

  typedef enum logic [REQ_W-1:0] {
    REQ_SCHEDULE = 2'd0,
    REQ_CANCEL   = 2'd1,
    REQ_TICK     = 2'd2,
    REQ_FLUSH    = 2'd3
  } req_e;

  typedef enum logic [KIND_W-1:0] {
    RESP_SCHEDULED = 3'd0,
    RESP_REFUSED   = 3'd1,
    RESP_CANCELLED = 3'd2,
    RESP_NOT_FOUND = 3'd3,
    RESP_EXPIRED   = 3'd4,
    RESP_FLUSHED   = 3'd5
  } resp_e;

  typedef enum logic [1:0] {
    ALU_ADD_SAT = 2'd0,
    ALU_GE      = 2'd1,
    ALU_EQ      = 2'd2
  } alu_op_e;

  typedef enum logic [2:0] {
    ST_IDLE      = 3'd0,
    ST_PREP      = 3'd1,
    ST_INS_WALK  = 3'd2,
    ST_INS_PUT   = 3'd3,
    ST_CAN_WALK  = 3'd4,
    ST_CAN_DONE  = 3'd5,
    ST_TICK_RD   = 3'd6,
    ST_TICK_EVAL = 3'd7
  } state_e;

endpackage

>>> hdl/stq_req_if.sv
// ----------------------------------------------------------------------------
// stq_req_if
// Request channel of the timer queue: valid/ready plus one request item.
// ----------------------------------------------------------------------------
interface stq_req_if
  import stq_pkg::*;
();
  logic                    valid;
  logic                    ready;
  logic [REQ_W-1:0]        req_type;
  logic [FIELD_TIME_W-1:0] now_time;
  logic [FIELD_TIME_W-1:0] timeout;
  logic                    is_relative;
  logic [JOB_W-1:0]        job_handle;
  logic                    persistent;
  logic [FIELD_ID_W-1:0]   cancel_id;

  modport source (
    output valid, req_type, now_time, timeout, is_relative, job_handle,
           persistent, cancel_id,
    input  ready
  );

  modport sink (
    input  valid, req_type, now_time, timeout, is_relative, job_handle,
           persistent, cancel_id,
    output ready
  );
endinterface

>>> hdl/stq_resp_if.sv
// ----------------------------------------------------------------------------
// stq_resp_if
// Response channel of the timer queue: valid/ready plus one result item.
// ----------------------------------------------------------------------------
interface stq_resp_if
  import stq_pkg::*;
();
  logic                  valid;
  logic                  ready;
  logic [KIND_W-1:0]     resp_kind;
  logic [FIELD_ID_W-1:0] event_id;
  logic [JOB_W-1:0]      job_out;
  logic                  persistent_out;
  logic                  last;

  modport source (
    output valid, resp_kind, event_id, job_out, persistent_out, last,
    input  ready
  );

  modport sink (
    input  valid, resp_kind, event_id, job_out, persistent_out, last,
    output ready
  );
endinterface

>>> hdl/stq_ram.sv
// ----------------------------------------------------------------------------
// stq_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module stq_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 32
) (
  input  logic                     clk_i,
  input  logic                     wr_en_i,
  input  logic [$clog2(DEPTH)-1:0] wr_addr_i,
  input  logic [WIDTH-1:0]         wr_data_i,
  input  logic                     rd_en_i,
  input  logic [$clog2(DEPTH)-1:0] rd_addr_i,
  output logic [WIDTH-1:0]         rd_data_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      mem_q[wr_addr_i] <= wr_data_i;
    end
  end

  // read data holds while no read is issued
  always_ff @(posedge clk_i) begin
    if (rd_en_i) begin
      rd_data_o <= mem_q[rd_addr_i];
    end
  end

endmodule

>>> hdl/stq_alu.sv
// ----------------------------------------------------------------------------
// stq_alu
// Shared arithmetic unit: saturating add, unsigned greater-or-equal, equal.
// ----------------------------------------------------------------------------
module stq_alu
  import stq_pkg::*;
#(
  parameter int unsigned WIDTH     = 32,
  parameter int unsigned SAT_WIDTH = 32
) (
  input  alu_op_e          op_i,
  input  logic [WIDTH-1:0] a_i,
  input  logic [WIDTH-1:0] b_i,
  output logic [WIDTH-1:0] sum_o,
  output logic             flag_o
);

  localparam logic [WIDTH-1:0] SAT_MAX = WIDTH'({SAT_WIDTH{1'b1}});

  logic [WIDTH:0] sum_full;
  logic           ovf;

  assign sum_full = {1'b0, a_i} + {1'b0, b_i};
  // anything at or above the saturation width means overflow
  assign ovf      = |(sum_full >> SAT_WIDTH);
  assign sum_o    = ovf ? SAT_MAX : sum_full[WIDTH-1:0];

  always_comb begin
    case (op_i)
      ALU_GE:  flag_o = (a_i >= b_i);
      ALU_EQ:  flag_o = (a_i == b_i);
      default: flag_o = 1'b0;
    endcase
  end

endmodule

>>> hdl/sorted_timer_event_queue.sv
// Flush, refusal and cancel on an empty store load their result straight from
// prep; cancel walks every entry, schedule walks back from the tail over the
// entries at or after the new time, and tick reads and checks the head once per
// expired item until a later entry, an empty store or the result limit ends it.
// One request at a time; ready again once the sequencer is back in idle.
// Reset clears sequencer, count, next id, head and output valid, not the store.
// ----------------------------------------------------------------------------
// sorted_timer_event_queue
// Timer events kept sorted by expiry time in a circular RAM, walked by a
// small sequencer around one shared add/compare unit.
// ----------------------------------------------------------------------------
module sorted_timer_event_queue
  import stq_pkg::*;
#(
  parameter int unsigned DEPTH      = DEPTH_DEF,
  parameter int unsigned TIME_WIDTH = TIME_WIDTH_DEF,
  parameter int unsigned ID_WIDTH   = ID_WIDTH_DEF
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  stq_req_if.sink    req_i,
  stq_resp_if.source resp_o
);

  localparam int unsigned IDX_W   = $clog2(DEPTH);
  localparam int unsigned CNT_W   = $clog2(DEPTH + 1);
  localparam int unsigned N_W     = $clog2(MAX_RESULTS + 1);
  localparam int unsigned ALU_W   = (TIME_WIDTH > ID_WIDTH) ? TIME_WIDTH : ID_WIDTH;
  localparam int unsigned ENTRY_W = TIME_WIDTH + ID_WIDTH + JOB_W + 1;

  // ring position of a logical index counted from the head
  function automatic logic [IDX_W-1:0] phys(input logic [IDX_W-1:0] h,
                                            input logic [IDX_W-1:0] i);
    logic [IDX_W:0] s;
    s = {1'b0, h} + {1'b0, i};
    if (s >= (IDX_W+1)'(DEPTH)) begin
      s = s - (IDX_W+1)'(DEPTH);
    end
    return s[IDX_W-1:0];
  endfunction

  state_e state_q, state_d;

  // latched request
  req_e                  req_q;
  logic [TIME_WIDTH-1:0] now_q, tmo_q;
  logic                  rel_q, pers_q;
  logic [JOB_W-1:0]      job_q;
  logic [ID_WIDTH-1:0]   cid_q;

  // queue control
  logic [TIME_WIDTH-1:0] t_q, t_d;
  logic [IDX_W-1:0]      head_q, head_d;
  logic [CNT_W-1:0]      count_q, count_d;
  logic [ID_WIDTH-1:0]   next_id_q, next_id_d;
  logic [IDX_W-1:0]      idx_q, idx_d;
  logic [IDX_W-1:0]      put_q, put_d;
  logic                  found_q, found_d;
  logic [JOB_W-1:0]      fjob_q, fjob_d;
  logic [N_W-1:0]        n_q, n_d;

  // expired item held back until we know whether it is the last one
  logic                  pend_q, pend_d;
  logic [ID_WIDTH-1:0]   pend_id_q, pend_id_d;
  logic [JOB_W-1:0]      pend_job_q, pend_job_d;
  logic                  pend_pers_q, pend_pers_d;

  // output register
  logic                  ov_q;
  resp_e                 o_kind_q, o_kind_d;
  logic [FIELD_ID_W-1:0] o_id_q, o_id_d;
  logic [JOB_W-1:0]      o_job_q, o_job_d;
  logic                  o_pers_q, o_pers_d;
  logic                  o_last_q, o_last_d;
  logic                  out_load, out_free;

  // RAM
  logic                  rd_en, wr_en;
  logic [IDX_W-1:0]      rd_lidx, wr_lidx;
  logic [ENTRY_W-1:0]    wr_data, rd_data;
  logic [TIME_WIDTH-1:0] rd_time;
  logic [ID_WIDTH-1:0]   rd_id;
  logic [JOB_W-1:0]      rd_job;
  logic                  rd_pers;

  // shared unit
  alu_op_e               alu_op;
  logic [ALU_W-1:0]      alu_a, alu_b, alu_sum;
  logic                  alu_flag;

  logic                  req_acc;
  logic                  walk_end;
  logic                  tick_stop;

  assign rd_pers = rd_data[0];
  assign rd_job  = rd_data[JOB_W:1];
  assign rd_id   = rd_data[JOB_W+ID_WIDTH:JOB_W+1];
  assign rd_time = rd_data[ENTRY_W-1:JOB_W+ID_WIDTH+1];

  assign req_i.ready = (state_q == ST_IDLE);
  assign req_acc     = req_i.valid && req_i.ready;
  assign out_free    = !ov_q || resp_o.ready;
  assign walk_end    = ((CNT_W'(idx_q) + CNT_W'(1)) == count_q);
  assign tick_stop   = (count_q == '0) || (n_q == N_W'(MAX_RESULTS));

  stq_ram #(
    .WIDTH (ENTRY_W),
    .DEPTH (DEPTH)
  ) u_ram (
    .clk_i     (clk_i),
    .wr_en_i   (wr_en),
    .wr_addr_i (phys(head_q, wr_lidx)),
    .wr_data_i (wr_data),
    .rd_en_i   (rd_en),
    .rd_addr_i (phys(head_q, rd_lidx)),
    .rd_data_o (rd_data)
  );

  stq_alu #(
    .WIDTH     (ALU_W),
    .SAT_WIDTH (TIME_WIDTH)
  ) u_alu (
    .op_i   (alu_op),
    .a_i    (alu_a),
    .b_i    (alu_b),
    .sum_o  (alu_sum),
    .flag_o (alu_flag)
  );

  // next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE: begin
        if (req_acc) state_d = ST_PREP;
      end
      ST_PREP: begin
        case (req_q)
          REQ_SCHEDULE: begin
            if (count_q == CNT_W'(DEPTH)) begin
              if (out_free) state_d = ST_IDLE;
            end else if (count_q == '0) begin
              state_d = ST_INS_PUT;
            end else begin
              state_d = ST_INS_WALK;
            end
          end
          REQ_CANCEL: begin
            if (count_q == '0) begin
              if (out_free) state_d = ST_IDLE;
            end else begin
              state_d = ST_CAN_WALK;
            end
          end
          REQ_TICK: state_d = ST_TICK_RD;
          default: begin
            if (out_free) state_d = ST_IDLE;
          end
        endcase
      end
      ST_INS_WALK: begin
        if (!alu_flag || idx_q == '0) state_d = ST_INS_PUT;
      end
      ST_INS_PUT: begin
        if (out_free) state_d = ST_IDLE;
      end
      ST_CAN_WALK: begin
        if (walk_end) state_d = ST_CAN_DONE;
      end
      ST_CAN_DONE: begin
        if (out_free) state_d = ST_IDLE;
      end
      ST_TICK_RD: begin
        if (tick_stop) begin
          if (!pend_q || out_free) state_d = ST_IDLE;
        end else begin
          state_d = ST_TICK_EVAL;
        end
      end
      ST_TICK_EVAL: begin
        if (alu_flag) begin
          if (!pend_q || out_free) state_d = ST_TICK_RD;
        end else if (!pend_q || out_free) begin
          state_d = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  // datapath and memory control
  always_comb begin
    t_d         = t_q;
    head_d      = head_q;
    count_d     = count_q;
    next_id_d   = next_id_q;
    idx_d       = idx_q;
    put_d       = put_q;
    found_d     = found_q;
    fjob_d      = fjob_q;
    n_d         = n_q;
    pend_d      = pend_q;
    pend_id_d   = pend_id_q;
    pend_job_d  = pend_job_q;
    pend_pers_d = pend_pers_q;

    rd_en   = 1'b0;
    rd_lidx = idx_q;
    wr_en   = 1'b0;
    wr_lidx = idx_q;
    wr_data = rd_data;

    alu_op = ALU_GE;
    alu_a  = ALU_W'(rd_time);
    alu_b  = ALU_W'(t_q);

    out_load = 1'b0;
    o_kind_d = RESP_SCHEDULED;
    o_id_d   = '0;
    o_job_d  = '0;
    o_pers_d = 1'b0;
    o_last_d = 1'b1;

    case (state_q)
      ST_PREP: begin
        alu_op = ALU_ADD_SAT;
        alu_a  = ALU_W'(now_q);
        alu_b  = ALU_W'(tmo_q);
        t_d    = rel_q ? alu_sum[TIME_WIDTH-1:0] : tmo_q;
        case (req_q)
          REQ_SCHEDULE: begin
            if (count_q == CNT_W'(DEPTH)) begin
              out_load = out_free;
              o_kind_d = RESP_REFUSED;
            end else if (count_q == '0) begin
              put_d = '0;
            end else begin
              // walk from the tail toward the head
              rd_en   = 1'b1;
              rd_lidx = IDX_W'(count_q - CNT_W'(1));
              idx_d   = rd_lidx;
            end
          end
          REQ_CANCEL: begin
            found_d = 1'b0;
            if (count_q == '0) begin
              out_load = out_free;
              o_kind_d = RESP_NOT_FOUND;
              o_id_d   = FIELD_ID_W'(cid_q);
            end else begin
              rd_en   = 1'b1;
              rd_lidx = '0;
              idx_d   = '0;
            end
          end
          REQ_TICK: begin
            n_d    = '0;
            pend_d = 1'b0;
          end
          default: begin
            out_load = out_free;
            o_kind_d = RESP_FLUSHED;
            if (out_free) count_d = '0;
          end
        endcase
      end
      ST_INS_WALK: begin
        // entry time >= new time: move it one place back
        if (alu_flag) begin
          wr_en   = 1'b1;
          wr_lidx = idx_q + IDX_W'(1);
          if (idx_q == '0) begin
            put_d = '0;
          end else begin
            rd_en   = 1'b1;
            rd_lidx = idx_q - IDX_W'(1);
            idx_d   = rd_lidx;
          end
        end else begin
          put_d = idx_q + IDX_W'(1);
        end
      end
      ST_INS_PUT: begin
        if (out_free) begin
          wr_en     = 1'b1;
          wr_lidx   = put_q;
          wr_data   = {t_q, next_id_q, job_q, pers_q};
          count_d   = count_q + CNT_W'(1);
          next_id_d = next_id_q + ID_WIDTH'(1);
          out_load  = 1'b1;
          o_kind_d  = RESP_SCHEDULED;
          o_id_d    = FIELD_ID_W'(next_id_q);
        end
      end
      ST_CAN_WALK: begin
        alu_op = ALU_EQ;
        alu_a  = ALU_W'(rd_id);
        alu_b  = ALU_W'(cid_q);
        if (found_q) begin
          // close the gap behind the removed entry
          wr_en   = 1'b1;
          wr_lidx = idx_q - IDX_W'(1);
        end else if (alu_flag) begin
          found_d = 1'b1;
          fjob_d  = rd_job;
        end
        if (!walk_end) begin
          rd_en   = 1'b1;
          rd_lidx = idx_q + IDX_W'(1);
          idx_d   = rd_lidx;
        end
      end
      ST_CAN_DONE: begin
        out_load = out_free;
        o_id_d   = FIELD_ID_W'(cid_q);
        if (found_q) begin
          o_kind_d = RESP_CANCELLED;
          o_job_d  = fjob_q;
          if (out_free) count_d = count_q - CNT_W'(1);
        end else begin
          o_kind_d = RESP_NOT_FOUND;
        end
      end
      ST_TICK_RD: begin
        o_kind_d = RESP_EXPIRED;
        o_id_d   = FIELD_ID_W'(pend_id_q);
        o_job_d  = pend_job_q;
        o_pers_d = pend_pers_q;
        if (tick_stop) begin
          out_load = pend_q && out_free;
        end else begin
          rd_en   = 1'b1;
          rd_lidx = '0;
        end
      end
      ST_TICK_EVAL: begin
        alu_a    = ALU_W'(now_q);
        alu_b    = ALU_W'(rd_time);
        o_kind_d = RESP_EXPIRED;
        o_id_d   = FIELD_ID_W'(pend_id_q);
        o_job_d  = pend_job_q;
        o_pers_d = pend_pers_q;
        if (alu_flag) begin
          // head is due: send the held item, hold this one
          o_last_d = 1'b0;
          if (!pend_q || out_free) begin
            out_load    = pend_q;
            pend_d      = 1'b1;
            pend_id_d   = rd_id;
            pend_job_d  = rd_job;
            pend_pers_d = rd_pers;
            head_d      = phys(head_q, IDX_W'(1));
            count_d     = count_q - CNT_W'(1);
            n_d         = n_q + N_W'(1);
          end
        end else begin
          out_load = pend_q && out_free;
        end
      end
      default: ;
    endcase
  end

  // control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= ST_IDLE;
      head_q    <= '0;
      count_q   <= '0;
      next_id_q <= '0;
      pend_q    <= 1'b0;
      ov_q      <= 1'b0;
    end else begin
      state_q   <= state_d;
      head_q    <= head_d;
      count_q   <= count_d;
      next_id_q <= next_id_d;
      pend_q    <= pend_d;
      if (out_load) begin
        ov_q <= 1'b1;
      end else if (resp_o.ready) begin
        ov_q <= 1'b0;
      end
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    if (req_acc) begin
      req_q  <= req_e'(req_i.req_type);
      now_q  <= TIME_WIDTH'(req_i.now_time);
      tmo_q  <= TIME_WIDTH'(req_i.timeout);
      rel_q  <= req_i.is_relative;
      job_q  <= req_i.job_handle;
      pers_q <= req_i.persistent;
      cid_q  <= ID_WIDTH'(req_i.cancel_id);
    end
    t_q         <= t_d;
    idx_q       <= idx_d;
    put_q       <= put_d;
    found_q     <= found_d;
    fjob_q      <= fjob_d;
    n_q         <= n_d;
    pend_id_q   <= pend_id_d;
    pend_job_q  <= pend_job_d;
    pend_pers_q <= pend_pers_d;
    if (out_load) begin
      o_kind_q <= o_kind_d;
      o_id_q   <= o_id_d;
      o_job_q  <= o_job_d;
      o_pers_q <= o_pers_d;
      o_last_q <= o_last_d;
    end
  end

  assign resp_o.valid          = ov_q;
  assign resp_o.resp_kind      = o_kind_q;
  assign resp_o.event_id       = o_id_q;
  assign resp_o.job_out        = o_job_q;
  assign resp_o.persistent_out = o_pers_q;
  assign resp_o.last           = o_last_q;

endmodule

>>> verif/sorted_timer_event_queue_checker.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// sorted_timer_event_queue_checker
// Watches the request and response channels of the timer queue. It keeps
// its own copy of the sorted event store and works out the results of every
// accepted request. Each accepted response is compared in order against
// those predictions, and the mismatch and outstanding counts are passed up.
// ----------------------------------------------------------------------------
module sorted_timer_event_queue_checker
  import stq_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  stq_req_if          req_i,
  stq_resp_if         resp_i,
  output int unsigned mismatch_cnt_o,
  output int unsigned pending_o
);

  localparam int SLOTS        = DEPTH_DEF;
  localparam int REPORT_LIMIT = 10;

  typedef struct packed {
    resp_e                 kind;
    logic [FIELD_ID_W-1:0] id;
    logic [JOB_W-1:0]      job;
    logic                  pers;
    logic                  last;
  } timer_result_t;

  // Predicted store, earliest expiry at index 0
  logic [FIELD_TIME_W-1:0] ev_time [SLOTS];
  logic [FIELD_ID_W-1:0]   ev_id   [SLOTS];
  logic [JOB_W-1:0]        ev_job  [SLOTS];
  logic                    ev_pers [SLOTS];
  int                      ev_count;
  logic [FIELD_ID_W-1:0]   id_next;

  timer_result_t awaited_q[$];
  int unsigned   mismatches;

  function automatic timer_result_t make_result(resp_e kind, logic [FIELD_ID_W-1:0] id,
                                                logic [JOB_W-1:0] job, logic pers,
                                                logic last);
    timer_result_t r;
    r.kind = kind;
    r.id   = id;
    r.job  = job;
    r.pers = pers;
    r.last = last;
    return r;
  endfunction

  task automatic drop_entry(input int pos);
    for (int i = pos; i + 1 < ev_count; i++) begin
      ev_time[i] = ev_time[i+1];
      ev_id[i]   = ev_id[i+1];
      ev_job[i]  = ev_job[i+1];
      ev_pers[i] = ev_pers[i+1];
    end
    ev_count--;
  endtask

  task automatic predict_request(input req_e kind, input logic [FIELD_TIME_W-1:0] now,
                                 input logic [FIELD_TIME_W-1:0] tmo, input logic rel,
                                 input logic [JOB_W-1:0] job, input logic pers,
                                 input logic [FIELD_ID_W-1:0] cid);
    logic [FIELD_TIME_W:0]   sum;
    logic [FIELD_TIME_W-1:0] due;
    int                      pos;
    int                      n;
    case (kind)
      REQ_SCHEDULE: begin
        sum = {1'b0, now} + {1'b0, tmo};
        due = !rel ? tmo : (sum[FIELD_TIME_W] ? '1 : sum[FIELD_TIME_W-1:0]);
        if (ev_count >= SLOTS) begin
          awaited_q.push_back(make_result(RESP_REFUSED, '0, '0, 1'b0, 1'b1));
        end else begin
          // new event goes ahead of the first one due at the same time or later
          pos = ev_count;
          for (int i = ev_count - 1; i >= 0; i--)
            if (ev_time[i] >= due) pos = i;
          for (int i = ev_count; i > pos; i--) begin
            ev_time[i] = ev_time[i-1];
            ev_id[i]   = ev_id[i-1];
            ev_job[i]  = ev_job[i-1];
            ev_pers[i] = ev_pers[i-1];
          end
          ev_time[pos] = due;
          ev_id[pos]   = id_next;
          ev_job[pos]  = job;
          ev_pers[pos] = pers;
          ev_count++;
          awaited_q.push_back(make_result(RESP_SCHEDULED, id_next, '0, 1'b0, 1'b1));
          id_next = id_next + 1'b1;
        end
      end
      REQ_CANCEL: begin
        // with duplicate ids the earliest-expiring one goes
        pos = -1;
        for (int i = ev_count - 1; i >= 0; i--)
          if (ev_id[i] == cid) pos = i;
        if (pos < 0) begin
          awaited_q.push_back(make_result(RESP_NOT_FOUND, cid, '0, 1'b0, 1'b1));
        end else begin
          awaited_q.push_back(make_result(RESP_CANCELLED, cid, ev_job[pos], 1'b0, 1'b1));
          drop_entry(pos);
        end
      end
      REQ_TICK: begin
        n = 0;
        while (n < int'(MAX_RESULTS) && ev_count > 0 && ev_time[0] <= now) begin
          awaited_q.push_back(make_result(RESP_EXPIRED, ev_id[0], ev_job[0], ev_pers[0],
                                          1'b0));
          drop_entry(0);
          n++;
        end
        if (n > 0) awaited_q[awaited_q.size()-1].last = 1'b1;
      end
      REQ_FLUSH: begin
        ev_count = 0;
        awaited_q.push_back(make_result(RESP_FLUSHED, '0, '0, 1'b0, 1'b1));
      end
      default: ;
    endcase
  endtask

  task automatic note_mismatch(input string what, input timer_result_t want,
                               input timer_result_t got);
    mismatches++;
    if (mismatches <= REPORT_LIMIT) begin
      $display("[%0t] %s: expected kind %0d id %h job %h pers %b last %b",
               $time, what, want.kind, want.id, want.job, want.pers, want.last);
      $display("  got kind %0d id %h job %h pers %b last %b",
               got.kind, got.id, got.job, got.pers, got.last);
    end
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    timer_result_t got;
    timer_result_t want;
    if (!rst_ni) begin
      ev_count = 0;
      id_next  = '0;
      awaited_q.delete();
      mismatches = 0;
      mismatch_cnt_o <= 0;
      pending_o      <= 0;
    end else begin
      // responses first: one accepted now can only belong to an older request
      if (resp_i.valid && resp_i.ready) begin
        got = make_result(resp_e'(resp_i.resp_kind), resp_i.event_id, resp_i.job_out,
                          resp_i.persistent_out, resp_i.last);
        if (awaited_q.size() == 0) begin
          note_mismatch("result with nothing outstanding", '0, got);
        end else begin
          want = awaited_q.pop_front();
          if (got !== want) note_mismatch("result mismatch", want, got);
        end
      end
      if (req_i.valid && req_i.ready)
        predict_request(req_e'(req_i.req_type), req_i.now_time, req_i.timeout,
                        req_i.is_relative, req_i.job_handle, req_i.persistent,
                        req_i.cancel_id);
      mismatch_cnt_o <= mismatches;
      pending_o      <= awaited_q.size();
    end
  end

endmodule

>>> verif/sorted_timer_event_queue_tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// sorted_timer_event_queue_tb
// Drives schedule, cancel, tick and flush requests into the timer queue with
// random gaps and response stalls: a directed opening, then random traffic
// with bursts that overfill the store. The checker beside the block judges
// every response; this module gives the verdict.
// ----------------------------------------------------------------------------
module sorted_timer_event_queue_tb
  import stq_pkg::*;
();

  localparam int unsigned RANDOM_ITEMS = 280;
  localparam int unsigned IDLE_LIMIT   = 2000;
  localparam int unsigned DRAIN_CYCLES = 100;
  localparam int unsigned SLOTS        = DEPTH_DEF;

  logic                    clk;
  logic                    rst_n;
  bit                      gaps_on;
  logic [FIELD_TIME_W-1:0] clock_now;
  logic [FIELD_ID_W-1:0]   live_ids[$];
  int unsigned             idle_cycles;
  int unsigned             mismatch_cnt;
  int unsigned             pending_cnt;

  stq_req_if  req_if ();
  stq_resp_if resp_if ();

  sorted_timer_event_queue u_dut (
    .clk_i  (clk),
    .rst_ni (rst_n),
    .req_i  (req_if),
    .resp_o (resp_if)
  );

  sorted_timer_event_queue_checker u_chk (
    .clk_i          (clk),
    .rst_ni         (rst_n),
    .req_i          (req_if),
    .resp_i         (resp_if),
    .mismatch_cnt_o (mismatch_cnt),
    .pending_o      (pending_cnt)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  function automatic int unsigned idle_len();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (!gaps_on || r < 50) return 0;
    if (r < 88) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  // Called at a falling edge; returns at the falling edge after acceptance
  task automatic send_request(input req_e kind, input logic [FIELD_TIME_W-1:0] now,
                              input logic [FIELD_TIME_W-1:0] tmo, input logic rel,
                              input logic [JOB_W-1:0] job, input logic pers,
                              input logic [FIELD_ID_W-1:0] cid);
    int unsigned gap;
    gap = idle_len();
    if (gap > 0) begin
      req_if.valid = 1'b0;
      repeat (gap) @(negedge clk);
    end
    req_if.valid       = 1'b1;
    req_if.req_type    = kind;
    req_if.now_time    = now;
    req_if.timeout     = tmo;
    req_if.is_relative = rel;
    req_if.job_handle  = job;
    req_if.persistent  = pers;
    req_if.cancel_id   = cid;
    do @(posedge clk); while (!req_if.ready);
    @(negedge clk);
  endtask

  task automatic wait_drained();
    while (pending_cnt != 0) @(posedge clk);
    @(negedge clk);
  endtask

  task automatic send_random_schedule();
    logic                    rel;
    logic [FIELD_TIME_W-1:0] tmo;
    rel = 1'($urandom_range(0, 1));
    case ($urandom_range(0, 9))
      0:       tmo = $urandom();
      1:       tmo = '1 - $urandom_range(0, 255);
      default: tmo = $urandom_range(0, 40);
    endcase
    // absolute times mostly land just after the current time
    if (!rel && tmo <= 40) tmo = clock_now + tmo;
    send_request(REQ_SCHEDULE, clock_now, tmo, rel, 16'($urandom()), 1'($urandom()),
                 16'($urandom()));
  endtask

  task automatic send_random_item();
    int unsigned           pick;
    logic [FIELD_ID_W-1:0] cid;
    pick = $urandom_range(0, 99);
    if (pick < 45) begin
      send_random_schedule();
    end else if (pick < 68) begin
      if (live_ids.size() != 0 && $urandom_range(0, 3) != 0)
        cid = live_ids[$urandom_range(0, live_ids.size() - 1)];
      else
        cid = 16'($urandom());
      send_request(REQ_CANCEL, $urandom(), $urandom(), 1'($urandom()), 16'($urandom()),
                   1'($urandom()), cid);
    end else if (pick < 97) begin
      case ($urandom_range(0, 19))
        0:       clock_now = $urandom();
        1:       clock_now = '1 - $urandom_range(0, 63);
        default: clock_now = clock_now + $urandom_range(0, 60);
      endcase
      send_request(REQ_TICK, clock_now, $urandom(), 1'($urandom()), 16'($urandom()),
                   1'($urandom()), 16'($urandom()));
    end else begin
      send_request(REQ_FLUSH, $urandom(), $urandom(), 1'($urandom()), 16'($urandom()),
                   1'($urandom()), 16'($urandom()));
    end
  endtask

  // Response ready with random stalls
  initial begin
    int unsigned stall;
    stall = 0;
    resp_if.ready = 1'b0;
    @(posedge rst_n);
    forever begin
      @(negedge clk);
      if (stall > 0) begin
        resp_if.ready = 1'b0;
        stall--;
      end else begin
        resp_if.ready = 1'b1;
        if ($urandom_range(0, 3) == 0) stall = idle_len();
      end
    end
  end

  // Track ids the block handed out, so cancels mostly hit
  always @(posedge clk) begin
    if (rst_n && resp_if.valid && resp_if.ready) begin
      case (resp_e'(resp_if.resp_kind))
        RESP_SCHEDULED: begin
          live_ids.push_back(resp_if.event_id);
        end
        RESP_CANCELLED, RESP_EXPIRED: begin
          for (int i = 0; i < live_ids.size(); i++)
            if (live_ids[i] == resp_if.event_id) begin
              live_ids.delete(i);
              break;
            end
        end
        RESP_FLUSHED: live_ids.delete();
        default: ;
      endcase
    end
  end

  always @(posedge clk) begin
    if ((req_if.valid && req_if.ready) || (resp_if.valid && resp_if.ready))
      idle_cycles <= 0;
    else
      idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= IDLE_LIMIT) begin
      $display("TB_ERROR");
      $finish;
    end
  end

  initial begin
    int unsigned sent;
    rst_n              = 1'b0;
    gaps_on            = 1'b1;
    clock_now          = '0;
    idle_cycles        = 0;
    req_if.valid       = 1'b0;
    req_if.req_type    = REQ_SCHEDULE;
    req_if.now_time    = '0;
    req_if.timeout     = '0;
    req_if.is_relative = 1'b0;
    req_if.job_handle  = '0;
    req_if.persistent  = 1'b0;
    req_if.cancel_id   = '0;
    repeat (7) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;
    @(negedge clk);

    // Directed opening
    send_request(REQ_TICK,     32'd0,         32'd0,         1'b0, 16'h0000, 1'b0, 16'h0000);
    send_request(REQ_CANCEL,   32'd0,         32'd0,         1'b0, 16'h0000, 1'b0, 16'hFFFF);
    send_request(REQ_SCHEDULE, 32'd0,         32'd0,         1'b0, 16'hFFFF, 1'b1, 16'h0000);
    send_request(REQ_SCHEDULE, 32'd0,         32'hFFFF_FFFF, 1'b0, 16'h0000, 1'b0, 16'h0000);
    // relative timeouts past the top of the range saturate
    send_request(REQ_SCHEDULE, 32'hFFFF_FFF0, 32'h0000_0100, 1'b1, 16'h1234, 1'b1, 16'h0000);
    send_request(REQ_SCHEDULE, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 1'b1, 16'h8001, 1'b0, 16'h0000);
    // three events due at the same time
    send_request(REQ_SCHEDULE, 32'd0,         32'd100,       1'b0, 16'hAAAA, 1'b0, 16'h0000);
    send_request(REQ_SCHEDULE, 32'd0,         32'd100,       1'b0, 16'h5555, 1'b1, 16'h0000);
    send_request(REQ_SCHEDULE, 32'd50,        32'd50,        1'b1, 16'h0F0F, 1'b1, 16'h0000);
    send_request(REQ_CANCEL,   32'd0,         32'd0,         1'b0, 16'h0000, 1'b0, 16'd5);
    send_request(REQ_CANCEL,   32'd0,         32'd0,         1'b0, 16'h0000, 1'b0, 16'd5);
    send_request(REQ_CANCEL,   32'd0,         32'd0,         1'b0, 16'h0000, 1'b0, 16'd0);
    send_request(REQ_TICK,     32'd99,        32'd0,         1'b0, 16'h0000, 1'b0, 16'h0000);
    send_request(REQ_TICK,     32'd100,       32'd0,         1'b0, 16'h0000, 1'b0, 16'h0000);
    send_request(REQ_TICK,     32'hFFFF_FFFE, 32'd0,         1'b0, 16'h0000, 1'b0, 16'h0000);
    send_request(REQ_TICK,     32'hFFFF_FFFF, 32'd0,         1'b0, 16'h0000, 1'b0, 16'h0000);
    send_request(REQ_SCHEDULE, 32'd0,         32'd7,         1'b0, 16'hC3C3, 1'b1, 16'h0000);
    send_request(REQ_FLUSH,    32'd0,         32'd0,         1'b0, 16'h0000, 1'b0, 16'h0000);
    send_request(REQ_TICK,     32'hFFFF_FFFF, 32'd0,         1'b0, 16'h0000, 1'b0, 16'h0000);
    send_request(REQ_CANCEL,   32'd0,         32'd0,         1'b0, 16'h0000, 1'b0, 16'd7);

    // Random traffic
    gaps_on = 1'b1;
    sent = 0;
    while (sent < RANDOM_ITEMS) begin
      if ($urandom_range(0, 29) == 0) gaps_on = ($urandom_range(0, 3) != 0);
      if ($urandom_range(0, 39) == 0) begin
        // overfill the store to draw refusals
        repeat (SLOTS + 3) send_random_schedule();
        sent += SLOTS + 3;
      end else begin
        send_random_item();
        sent++;
      end
    end

    req_if.valid = 1'b0;
    wait_drained();
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (mismatch_cnt == 0 && pending_cnt == 0)
      $display("TB_OK");
    else
      $display("TB_ERROR");
    $finish;
  end

endmodule
